@@ rtl/mlpf_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and the tanh table of the perceptron engine
package mlpf_pkg;

	localparam int MAX_INPUTS       = 16;
	localparam int MAX_HIDDEN       = 32;
	localparam int MAX_OUTPUTS      = 8;
	localparam int TANH_TABLE_DEPTH = 256;

	localparam int IN_AW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int HID_AW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
	localparam int OUT_AW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int TAB_AW  = $clog2(TANH_TABLE_DEPTH);
	localparam int TAB_SH  = 27 - TAB_AW;
	localparam int W1_AW   = IN_AW + HID_AW;
	localparam int W2_AW   = HID_AW + OUT_AW;
	localparam int CNT_W   = 7;
	localparam int ACC_W   = 40;
	localparam int HV_W    = 14;

	typedef enum logic [2:0] {
		CMD_W1   = 3'd0,
		CMD_W2   = 3'd1,
		CMD_HB   = 3'd2,
		CMD_OB   = 3'd3,
		CMD_ELEM = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_INPUTS  = 2'd0,
		REG_HIDDEN  = 2'd1,
		REG_OUTPUTS = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_L1_RUN,
		ST_L1_WAIT,
		ST_L2_RUN,
		ST_L2_WAIT
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic bias;
	} term_ctl_t;

	typedef logic signed [HV_W-1:0] tanh_tab_t [TANH_TABLE_DEPTH];

	// shift and subtract quotient of two non-negative numbers, elaboration only
	function automatic longint udiv(longint n, longint q);
		longint quo;
		longint rem;
		quo = 0;
		rem = 0;
		for (int b = 62; b >= 0; b--) begin
			rem = (rem <<< 1) | ((n >>> b) & 64'sd1);
			quo = quo <<< 1;
			if (rem >= q) begin
				rem = rem - q;
				quo = quo | 64'sd1;
			end
		end
		return quo;
	endfunction

	function automatic tanh_tab_t build_tanh();
		tanh_tab_t tab;
		longint d;
		longint m;
		longint w;
		longint sum;
		longint term;
		longint num;
		longint den;
		longint t;
		logic neg;
		d = TANH_TABLE_DEPTH;
		for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
			m = 2 * longint'(i) + 1 - d;
			neg = (m < 0);
			if (neg) m = -m;
			w = (m <<< 30) >>> (TAB_AW + 1);
			sum = 64'sd1 <<< 30;
			term = 64'sd1 <<< 30;
			for (int k = 1; k <= 14; k++) begin
				term = udiv((term * w) >>> 30, longint'(k));
				if (k[0]) sum = sum - term;
				else sum = sum + term;
			end
			for (int s = 0; s < 4; s++) sum = (sum * sum) >>> 30;
			num = ((64'sd1 <<< 30) - sum) * 4096;
			den = (64'sd1 <<< 30) + sum;
			t = udiv(num + (den >>> 1), den);
			tab[i] = HV_W'(neg ? -t : t);
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

@@ rtl/mlp_forward_tanh.sv @@
`timescale 1ns / 1ps
// two-layer perceptron inference engine, top level
// Load words (weights, biases, input elements other than the last) are taken while the engine is idle.
// The input element at position inputs_in_use-1 starts an inference; no word is taken until
// it ends. One shared multiply-accumulate pipeline does one product a cycle while it runs and
// the output queue is not full; each neuron costs its products, its bias and the pipeline
// drain. Hidden values live in a chain of cells that shifts on every hidden result and
// rotates while the output layer reads them. Results pass through an output queue as deep as
// the maximum number of outputs; the output layer pauses when it is full. Weight stores and
// the input buffer hold nothing useful until written.
module mlp_forward_tanh (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [5:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          cmd,
	input  logic [4:0]          row,
	input  logic [4:0]          col,
	input  logic signed [15:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          out_index,
	output logic signed [13:0]  out_value,
	output logic                last
);

	localparam int NH  = mlpf_pkg::MAX_HIDDEN;
	localparam int NI  = mlpf_pkg::MAX_INPUTS;
	localparam int NO  = mlpf_pkg::MAX_OUTPUTS;
	localparam int CW  = mlpf_pkg::CNT_W;
	localparam int HVW = mlpf_pkg::HV_W;

	mlpf_pkg::state_t state_q, state_d;

	logic [4:0] n_in_q;
	logic [5:0] n_hid_q;
	logic [3:0] n_out_q;

	logic [CW-1:0] term_q, nrn_q, term_lim, nrn_lim;

	logic signed [15:0] w1_mem [NI*NH];
	logic signed [15:0] w2_mem [NH*NO];
	logic signed [15:0] w_rd_q;
	logic signed [15:0] ibuf_q [NI];
	logic signed [15:0] hb_q [NH];
	logic signed [15:0] ob_q [NO];

	logic signed [HVW-1:0] hv [NH];
	logic signed [HVW-1:0] chain_in, tap;
	logic                  chain_shift;

	logic                  acc_in, start, issue, is_bias, res_valid, nrn_end;
	logic signed [HVW-1:0] res;
	mlpf_pkg::term_ctl_t   ctl;
	logic signed [15:0]    x_op, b_op;

	logic [2:0]            fifo_idx_q [NO];
	logic signed [HVW-1:0] fifo_val_q [NO];
	logic                  fifo_last_q [NO];
	logic [mlpf_pkg::OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [mlpf_pkg::OUT_AW:0]   fifo_cnt_q;
	logic                  fifo_wr, fifo_rd, fifo_full;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_in_q  <= 5'(NI);
			n_hid_q <= 6'(NH);
			n_out_q <= 4'(NO);
		end else if (cfg_we) begin
			case (mlpf_pkg::reg_idx_t'(cfg_index))
				mlpf_pkg::REG_INPUTS: begin
					if (cfg_data[4:0] == 5'd0) n_in_q <= 5'd1;
					else if (5'(cfg_data[4:0]) > 5'(NI)) n_in_q <= 5'(NI);
					else n_in_q <= cfg_data[4:0];
				end
				mlpf_pkg::REG_HIDDEN: begin
					if (cfg_data == 6'd0) n_hid_q <= 6'd1;
					else if (cfg_data > 6'(NH)) n_hid_q <= 6'(NH);
					else n_hid_q <= cfg_data;
				end
				mlpf_pkg::REG_OUTPUTS: begin
					if (cfg_data[3:0] == 4'd0) n_out_q <= 4'd1;
					else if (cfg_data[3:0] > 4'(NO)) n_out_q <= 4'(NO);
					else n_out_q <= cfg_data[3:0];
				end
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == mlpf_pkg::ST_IDLE);
	assign acc_in   = in_valid & in_ready;
	assign start    = acc_in && (mlpf_pkg::cmd_t'(cmd) == mlpf_pkg::CMD_ELEM)
	                  && (32'(row) < NI) && (5'(row) == n_in_q - 5'd1);

	// stores
	always_ff @(posedge clk) begin
		if (acc_in && mlpf_pkg::cmd_t'(cmd) == mlpf_pkg::CMD_W1
		    && 32'(row) < NI && 32'(col) < NH) begin
			w1_mem[mlpf_pkg::W1_AW'(32'(row) * NH + 32'(col))] <= value;
		end
		if (acc_in && mlpf_pkg::cmd_t'(cmd) == mlpf_pkg::CMD_W2
		    && 32'(row) < NH && 32'(col) < NO) begin
			w2_mem[mlpf_pkg::W2_AW'(32'(row) * NO + 32'(col))] <= value;
		end
		if (acc_in && mlpf_pkg::cmd_t'(cmd) == mlpf_pkg::CMD_ELEM && 32'(row) < NI) begin
			ibuf_q[mlpf_pkg::IN_AW'(row)] <= value;
		end
		if (state_q == mlpf_pkg::ST_L1_RUN) begin
			w_rd_q <= w1_mem[mlpf_pkg::W1_AW'(32'(term_q) * NH + 32'(nrn_q))];
		end else begin
			w_rd_q <= w2_mem[mlpf_pkg::W2_AW'(32'(term_q) * NO + 32'(nrn_q))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NH; i++) hb_q[i] <= '0;
			for (int i = 0; i < NO; i++) ob_q[i] <= '0;
		end else begin
			if (acc_in && mlpf_pkg::cmd_t'(cmd) == mlpf_pkg::CMD_HB && 32'(row) < NH) begin
				hb_q[mlpf_pkg::HID_AW'(row)] <= value;
			end
			if (acc_in && mlpf_pkg::cmd_t'(cmd) == mlpf_pkg::CMD_OB && 32'(row) < NO) begin
				ob_q[mlpf_pkg::OUT_AW'(row)] <= value;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlpf_pkg::ST_IDLE;
			term_q  <= '0;
			nrn_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				term_q <= '0;
				nrn_q  <= '0;
			end else begin
				if (issue) term_q <= is_bias ? '0 : term_q + 1'b1;
				if (res_valid && (state_q == mlpf_pkg::ST_L1_WAIT
				                  || state_q == mlpf_pkg::ST_L2_WAIT)) begin
					nrn_q <= nrn_end ? '0 : nrn_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		term_lim = CW'(n_in_q);
		nrn_lim  = CW'(n_hid_q) - 1'b1;
		x_op     = ibuf_q[mlpf_pkg::IN_AW'(term_q)];
		b_op     = hb_q[mlpf_pkg::HID_AW'(nrn_q)];
		if (state_q == mlpf_pkg::ST_L2_RUN || state_q == mlpf_pkg::ST_L2_WAIT) begin
			term_lim = CW'(n_hid_q);
			nrn_lim  = CW'(n_out_q) - 1'b1;
			x_op     = 16'(tap);
			b_op     = ob_q[mlpf_pkg::OUT_AW'(nrn_q)];
		end
		is_bias = (term_q == term_lim);
		nrn_end = (nrn_q == nrn_lim);
		case (state_q)
			mlpf_pkg::ST_IDLE: begin
				if (start) state_d = mlpf_pkg::ST_L1_RUN;
			end
			mlpf_pkg::ST_L1_RUN: begin
				issue = 1'b1;
				if (is_bias) state_d = mlpf_pkg::ST_L1_WAIT;
			end
			mlpf_pkg::ST_L1_WAIT: begin
				if (res_valid) state_d = nrn_end ? mlpf_pkg::ST_L2_RUN : mlpf_pkg::ST_L1_RUN;
			end
			mlpf_pkg::ST_L2_RUN: begin
				issue = !fifo_full;
				if (issue && is_bias) state_d = mlpf_pkg::ST_L2_WAIT;
			end
			mlpf_pkg::ST_L2_WAIT: begin
				if (res_valid) state_d = nrn_end ? mlpf_pkg::ST_IDLE : mlpf_pkg::ST_L2_RUN;
			end
			default: state_d = mlpf_pkg::ST_IDLE;
		endcase
		ctl.valid = issue;
		ctl.first = issue && (term_q == '0);
		ctl.bias  = issue && is_bias;
	end

	mlpf_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.x         (x_op),
		.bias      (b_op),
		.w         (w_rd_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// hidden value chain
	assign tap = hv[mlpf_pkg::HID_AW'(n_hid_q - 6'd1)];

	always_comb begin
		chain_shift = 1'b0;
		chain_in    = tap;
		if (state_q == mlpf_pkg::ST_L1_WAIT && res_valid) begin
			chain_shift = 1'b1;
			chain_in    = res;
		end else if (state_q == mlpf_pkg::ST_L2_RUN && issue && !is_bias) begin
			chain_shift = 1'b1;
		end
	end

	for (genvar g = 0; g < NH; g++) begin : g_chain
		if (g == 0) begin : g_head
			mlpf_cell u_cell (.clk(clk), .shift(chain_shift), .d(chain_in), .q(hv[g]));
		end else begin : g_body
			mlpf_cell u_cell (.clk(clk), .shift(chain_shift), .d(hv[g-1]), .q(hv[g]));
		end
	end

	// output queue
	assign fifo_wr   = (state_q == mlpf_pkg::ST_L2_WAIT) && res_valid;
	assign fifo_rd   = out_valid && out_ready;
	assign fifo_full = (32'(fifo_cnt_q) == NO);

	always_ff @(posedge clk) begin
		if (fifo_wr) begin
			fifo_idx_q[wr_ptr_q]  <= 3'(nrn_q);
			fifo_val_q[wr_ptr_q]  <= res;
			fifo_last_q[wr_ptr_q] <= nrn_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (fifo_wr) begin
				wr_ptr_q <= (32'(wr_ptr_q) == NO - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (fifo_rd) begin
				rd_ptr_q <= (32'(rd_ptr_q) == NO - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({fifo_wr, fifo_rd})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign out_valid = (fifo_cnt_q != '0);
	assign out_index = fifo_idx_q[rd_ptr_q];
	assign out_value = fifo_val_q[rd_ptr_q];
	assign last      = fifo_last_q[rd_ptr_q];

endmodule

@@ rtl/mlpf_cell.sv @@
`timescale 1ns / 1ps
// one hidden value cell of the shifting chain
module mlpf_cell (
	input  logic                              clk,
	input  logic                              shift,
	input  logic signed [mlpf_pkg::HV_W-1:0]  d,
	output logic signed [mlpf_pkg::HV_W-1:0]  q
);

	logic signed [mlpf_pkg::HV_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

@@ rtl/mlpf_mac.sv @@
`timescale 1ns / 1ps
// multiply-accumulate pipeline with saturation and tanh activation
module mlpf_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mlpf_pkg::term_ctl_t               ctl,
	input  logic signed [15:0]                x,
	input  logic signed [15:0]                bias,
	input  logic signed [15:0]                w,
	output logic                              res_valid,
	output logic signed [mlpf_pkg::HV_W-1:0]  res
);

	localparam int AW = mlpf_pkg::ACC_W;

	mlpf_pkg::term_ctl_t ctl_s1, ctl_s2;
	logic signed [15:0]    x_s1, b_s1;
	logic signed [31:0]    term_s2;
	logic signed [AW-1:0]  acc_q;
	logic                  done_q;
	logic                  res_valid_q;
	logic signed [mlpf_pkg::HV_W-1:0] res_q;

	logic signed [AW:0]    sum;
	logic signed [AW-1:0]  sat;
	logic signed [AW-1:0]  four;
	logic signed [AW-1:0]  shifted;
	logic signed [mlpf_pkg::HV_W-1:0] act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			done_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			ctl_s1      <= ctl;
			ctl_s2      <= ctl_s1;
			done_q      <= ctl_s2.valid & ctl_s2.bias;
			res_valid_q <= done_q;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x;
		b_s1 <= bias;
		if (ctl_s1.bias) begin
			term_s2 <= 32'(b_s1) <<< 12;
		end else begin
			term_s2 <= x_s1 * w;
		end
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? AW'(term_s2) : sat;
		end
		res_q <= act;
	end

	always_comb begin
		sum = (AW+1)'(acc_q) + (AW+1)'(term_s2);
		if (sum[AW] != sum[AW-1]) begin
			sat = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			sat = sum[AW-1:0];
		end
	end

	always_comb begin
		four    = AW'(64'sd1 <<< 26);
		shifted = acc_q + four;
		if (acc_q >= four) begin
			act = mlpf_pkg::HV_W'(4096);
		end else if (acc_q < -four) begin
			act = -mlpf_pkg::HV_W'(4096);
		end else begin
			act = mlpf_pkg::TANH_TAB[shifted[26 -: mlpf_pkg::TAB_AW]];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ tb/tb_mlp_forward_tanh.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the two-layer tanh perceptron engine
module tb_mlp_forward_tanh;

	localparam logic [1:0] REG_NONE      = 2'd3;
	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
	localparam int         SETTLE        = 30;
	localparam int         RAND_WORDS    = 210;
	localparam int         LIM_IN        = 4;
	localparam int         LIM_HID       = 8;
	localparam longint     FOUR_Q24      = 64'sd4 <<< 24;
	localparam longint     ACC_MAX       = (64'sd1 <<< 39) - 1;
	localparam longint     ACC_MIN       = -(64'sd1 <<< 39);

	typedef struct {
		logic [2:0]         idx;
		logic signed [13:0] val;
		logic               lst;
	} outword_t;

	typedef struct {
		bit                 is_cfg;
		logic [2:0]         cmd;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [15:0] value;
		bit                 known;
		logic signed [13:0] exp_val;
	} step_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;
	logic in_valid, in_ready;
	logic [2:0] cmd;
	logic [4:0] row, col;
	logic signed [15:0] value;
	logic out_valid, out_ready;
	logic [2:0] out_index;
	logic signed [13:0] out_value;
	logic last;

	mlp_forward_tanh u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .row(row), .col(col), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_index(out_index), .out_value(out_value), .last(last)
	);

	// predictor state
	int lut [mlpf_pkg::TANH_TABLE_DEPTH];
	logic signed [15:0] w1 [mlpf_pkg::MAX_INPUTS*mlpf_pkg::MAX_HIDDEN];
	logic signed [15:0] w2 [mlpf_pkg::MAX_HIDDEN*mlpf_pkg::MAX_OUTPUTS];
	logic signed [15:0] hb [mlpf_pkg::MAX_HIDDEN];
	logic signed [15:0] ob [mlpf_pkg::MAX_OUTPUTS];
	logic signed [15:0] xb [mlpf_pkg::MAX_INPUTS];
	logic signed [15:0] hv [mlpf_pkg::MAX_HIDDEN];
	int n_in, n_hid, n_out;

	outword_t pending_outs[$];
	int errors = 0;
	int n_words = 0;
	int n_infer = 0;
	int n_checked = 0;
	bit calm = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void build_lut();
		longint d, m, w, sum, term, num, den, t;
		bit neg;
		d = mlpf_pkg::TANH_TABLE_DEPTH;
		for (int i = 0; i < mlpf_pkg::TANH_TABLE_DEPTH; i++) begin
			m = 2 * longint'(i) + 1 - d;
			neg = m < 0;
			if (neg) m = -m;
			w = (m << 30) / (2 * d);
			sum = 64'sd1 << 30;
			term = 64'sd1 << 30;
			for (int k = 1; k <= 14; k++) begin
				term = ((term * w) >>> 30) / k;
				sum = (k % 2) ? sum - term : sum + term;
			end
			repeat (4) sum = (sum * sum) >>> 30;
			num = ((64'sd1 << 30) - sum) * 4096;
			den = (64'sd1 << 30) + sum;
			t = (num + den / 2) / den;
			lut[i] = int'(neg ? -t : t);
		end
	endfunction

	function automatic longint acc_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > ACC_MAX) return ACC_MAX;
		if (s < ACC_MIN) return ACC_MIN;
		return s;
	endfunction

	function automatic int squash(longint a);
		longint k;
		if (a >= FOUR_Q24) return 4096;
		if (a < -FOUR_Q24) return -4096;
		k = ((a + FOUR_Q24) * mlpf_pkg::TANH_TABLE_DEPTH) >>> 27;
		if (k >= mlpf_pkg::TANH_TABLE_DEPTH) k = mlpf_pkg::TANH_TABLE_DEPTH - 1;
		return lut[int'(k)];
	endfunction

	function automatic int clamp_cnt(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [5:0] data);
		case (idx)
			mlpf_pkg::REG_INPUTS:  n_in  = clamp_cnt(int'(data[4:0]), mlpf_pkg::MAX_INPUTS);
			mlpf_pkg::REG_HIDDEN:  n_hid = clamp_cnt(int'(data), mlpf_pkg::MAX_HIDDEN);
			mlpf_pkg::REG_OUTPUTS: n_out = clamp_cnt(int'(data[3:0]), mlpf_pkg::MAX_OUTPUTS);
			default: ;
		endcase
	endfunction

	function automatic void run_inference();
		longint acc;
		outword_t ow;
		n_infer++;
		for (int h = 0; h < n_hid; h++) begin
			acc = 0;
			for (int j = 0; j < n_in; j++)
				acc = acc_add(acc, longint'(xb[j]) *
					longint'(w1[j*mlpf_pkg::MAX_HIDDEN+h]));
			acc = acc_add(acc, longint'(hb[h]) * 4096);
			hv[h] = 16'(squash(acc));
		end
		for (int o = 0; o < n_out; o++) begin
			acc = 0;
			for (int h = 0; h < n_hid; h++)
				acc = acc_add(acc, longint'(hv[h]) *
					longint'(w2[h*mlpf_pkg::MAX_OUTPUTS+o]));
			acc = acc_add(acc, longint'(ob[o]) * 4096);
			ow.idx = 3'(o);
			ow.val = 14'(squash(acc));
			ow.lst = (o + 1 == n_out);
			pending_outs.push_back(ow);
		end
	endfunction

	function automatic void apply_word(logic [2:0] c, logic [4:0] r, logic [4:0] k,
			logic signed [15:0] v);
		case (c)
			mlpf_pkg::CMD_W1:
				if (r < mlpf_pkg::MAX_INPUTS && k < mlpf_pkg::MAX_HIDDEN)
					w1[r*mlpf_pkg::MAX_HIDDEN+k] = v;
			mlpf_pkg::CMD_W2:
				if (r < mlpf_pkg::MAX_HIDDEN && k < mlpf_pkg::MAX_OUTPUTS)
					w2[r*mlpf_pkg::MAX_OUTPUTS+k] = v;
			mlpf_pkg::CMD_HB:   if (r < mlpf_pkg::MAX_HIDDEN) hb[r] = v;
			mlpf_pkg::CMD_OB:   if (r < mlpf_pkg::MAX_OUTPUTS) ob[r] = v;
			mlpf_pkg::CMD_ELEM: if (r < mlpf_pkg::MAX_INPUTS) begin
				xb[r] = v;
				if (r == n_in - 1) run_inference();
			end
			default: ;
		endcase
	endfunction

	// mostly small values so the activation stays off its rails
	function automatic logic signed [15:0] rand_q();
		if ($urandom_range(0, 7) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 4095)) - 16'sd2048;
	endfunction

	task automatic send_word(logic [2:0] c, logic [4:0] r, logic [4:0] k,
			logic signed [15:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		row <= r;
		col <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		apply_word(c, r, k, v);
		n_words++;
		if ($urandom_range(0, 29) == 0) calm = ~calm;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_outs.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [5:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_cfg(idx, data);
	endtask

	// receiving side
	int stall_left = 0;
	always @(posedge clk) begin
		outword_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outs.size() == 0) begin
				errors++;
				$display("%0t: unexpected word idx=%0d val=%0d last=%0b", $time,
					out_index, out_value, last);
			end else begin
				e = pending_outs.pop_front();
				n_checked++;
				if (out_index !== e.idx || out_value !== e.val || last !== e.lst) begin
					errors++;
					$display("%0t: mismatch exp idx=%0d val=%0d last=%0b got idx=%0d val=%0d last=%0b",
						$time, e.idx, e.val, e.lst, out_index, out_value, last);
				end
			end
			stall_left = calm ? 0 : $urandom_range(0, 10);
			if (stall_left > 0) out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0) out_ready <= 1'b1;
		end
	end

	step_t steps [] = '{
		'{1, mlpf_pkg::REG_INPUTS,  0, 0, 16'sd1,  0, 0},
		'{1, mlpf_pkg::REG_HIDDEN,  0, 0, 16'sd1,  0, 0},
		'{1, mlpf_pkg::REG_OUTPUTS, 0, 0, 16'sd1,  0, 0},
		'{0, mlpf_pkg::CMD_W1,   0,  0, 16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_W2,   0,  0, 16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 0,  0, 16'sh7fff, 1, 14'sd4096},
		'{0, mlpf_pkg::CMD_W2,   0,  0, -16'sh8000, 0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 0,  0, 16'sh7fff, 1, -14'sd4096},
		'{0, mlpf_pkg::CMD_HB,   0,  0, -16'sh8000, 0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 0,  0, 16'sh0000, 1, 14'sd4096},
		'{0, mlpf_pkg::CMD_OB,   0,  0, -16'sh8000, 0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 0,  0, 16'sh0000, 0, 0},
		'{0, CMD_SPARE_LO, 0, 0, 16'sh1234, 0, 0},
		'{0, CMD_SPARE_MID, 31, 31, -16'sh1, 0, 0},
		'{0, CMD_SPARE_HI, 0, 0, 16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_W1,   16, 0,  16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_W2,   0,  8,  16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_HB,   31, 0,  16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_OB,   8,  0,  16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 16, 0,  16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 31, 31, -16'sh8000, 0, 0},
		'{0, mlpf_pkg::CMD_OB,   0,  0,  16'sh7fff, 0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 0,  0,  -16'sh8000, 0, 0},
		'{1, REG_NONE,    0, 0, 16'sd0,  0, 0},
		'{1, mlpf_pkg::REG_INPUTS,  0, 0, 16'sd0,  0, 0},
		'{0, mlpf_pkg::CMD_ELEM, 0,  0,  16'sh0800, 0, 0}
	};

	initial begin
		int target;
		int kind;
		build_lut();
		for (int h = 0; h < mlpf_pkg::MAX_HIDDEN; h++) hb[h] = 0;
		for (int o = 0; o < mlpf_pkg::MAX_OUTPUTS; o++) ob[o] = 0;
		n_in = mlpf_pkg::MAX_INPUTS;
		n_hid = mlpf_pkg::MAX_HIDDEN;
		n_out = mlpf_pkg::MAX_OUTPUTS;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mlpf_pkg::REG_INPUTS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= mlpf_pkg::CMD_W1;
		row <= '0;
		col <= '0;
		value <= '0;
		out_ready <= 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				write_cfg(steps[i].cmd[1:0], steps[i].value[5:0]);
			else begin
				send_word(steps[i].cmd, steps[i].row, steps[i].col, steps[i].value);
				if (steps[i].known) pending_outs[pending_outs.size()-1].val = steps[i].exp_val;
			end
		end

		// fill every store the random part can read before anything random reads it
		write_cfg(mlpf_pkg::REG_INPUTS, 6'(LIM_IN));
		write_cfg(mlpf_pkg::REG_HIDDEN, 6'(LIM_HID));
		write_cfg(mlpf_pkg::REG_OUTPUTS, 6'd63);
		for (int j = 0; j < LIM_IN; j++)
			for (int h = 0; h < LIM_HID; h++)
				send_word(mlpf_pkg::CMD_W1, 5'(j), 5'(h), rand_q());
		for (int h = 0; h < LIM_HID; h++)
			for (int o = 0; o < mlpf_pkg::MAX_OUTPUTS; o++)
				send_word(mlpf_pkg::CMD_W2, 5'(h), 5'(o), rand_q());
		for (int h = 0; h < LIM_HID; h++) send_word(mlpf_pkg::CMD_HB, 5'(h), 5'd0, rand_q());
		for (int o = 0; o < mlpf_pkg::MAX_OUTPUTS; o++)
			send_word(mlpf_pkg::CMD_OB, 5'(o), 5'd0, rand_q());
		for (int j = 0; j < LIM_IN; j++) send_word(mlpf_pkg::CMD_ELEM, 5'(j), 5'd0, rand_q());

		target = n_words + RAND_WORDS;
		for (int ph = 0; n_words < target; ph++) begin
			if (ph == 0) begin
				write_cfg(mlpf_pkg::REG_INPUTS,  6'd1);
				write_cfg(mlpf_pkg::REG_HIDDEN,  6'd1);
				write_cfg(mlpf_pkg::REG_OUTPUTS, 6'd1);
			end else if (ph == 1) begin
				write_cfg(mlpf_pkg::REG_INPUTS,  6'(LIM_IN));
				write_cfg(mlpf_pkg::REG_HIDDEN,  6'(LIM_HID));
				write_cfg(mlpf_pkg::REG_OUTPUTS, 6'd63);
			end else begin
				write_cfg(mlpf_pkg::REG_INPUTS,  6'($urandom_range(0, LIM_IN)));
				write_cfg(mlpf_pkg::REG_HIDDEN,  6'($urandom_range(0, LIM_HID)));
				write_cfg(mlpf_pkg::REG_OUTPUTS, 6'($urandom_range(0, 63)));
			end
			if ($urandom_range(0, 3) == 0) write_cfg(REG_NONE, 6'($urandom));
			for (int k = 0; k < 60 && n_words < target; k++) begin
				if (k == 30 && ph == 2) drain();
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					for (int j = 0; j < n_in; j++)
						send_word(mlpf_pkg::CMD_ELEM, 5'(j), 5'($urandom), rand_q());
				end else if (kind == 6) begin
					send_word(mlpf_pkg::CMD_ELEM, 5'($urandom), 5'($urandom), 16'($urandom));
				end else if (kind == 7) begin
					send_word(3'($urandom_range(mlpf_pkg::CMD_W1, mlpf_pkg::CMD_OB)),
						5'($urandom), 5'($urandom), rand_q());
				end else if (kind == 8) begin
					send_word(3'($urandom_range(mlpf_pkg::CMD_W1, mlpf_pkg::CMD_OB)),
						5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)), rand_q());
				end else begin
					send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 5'($urandom),
						5'($urandom), 16'($urandom));
				end
			end
		end

		drain();
		$display("sent %0d words, %0d inferences predicted, %0d results checked",
			n_words, n_infer, n_checked);
		$display("sizes swept from one neuron per layer up to four inputs, eight hidden, eight out");
		if (errors == 0 && pending_outs.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d errors, %0d results never arrived", errors, pending_outs.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
